FILE: rtl/core/rpn_pkg.sv
// Shared types and codes for the RPN stack calculator.
`timescale 1ns / 1ps

package rpn_pkg;

    // Token function codes; codes six and seven are unused
    typedef enum logic [2:0] {
        FN_PUSH = 3'd0,
        FN_ADD  = 3'd1,
        FN_SUB  = 3'd2,
        FN_MUL  = 3'd3,
        FN_DIV  = 3'd4,
        FN_MOD  = 3'd5
    } fn_t;

    // Result status codes
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_UNDER  = 2'd1;
    localparam logic [1:0] STS_DIVZ   = 2'd2;
    localparam logic [1:0] STS_HALTED = 2'd3;

    localparam int WORD_W = 32;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIN_GET,
        S_CHK_B,
        S_LD_A,
        S_EXEC,
        S_EMIT
    } seq_state_t;

    // Arithmetic unit states
    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_SIGN,
        A_DONE
    } alu_state_t;

    // Sequencer to arithmetic unit
    typedef struct packed {
        logic       start;
        logic [2:0] func;
    } alu_ctl_t;

    // Arithmetic unit to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } alu_sts_t;

endpackage

FILE: rtl/core/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/rpn_alu.sv
// Shared arithmetic unit: direct add, subtract, multiply; iterative signed divide and modulo.
`timescale 1ns / 1ps

module rpn_alu (
    input  logic             aclk,
    input  logic             aresetn,
    input  rpn_pkg::alu_ctl_t ctl,
    input  logic [31:0]      a_in,
    input  logic [31:0]      b_in,
    output logic [31:0]      result,
    output rpn_pkg::alu_sts_t sts
);
    import rpn_pkg::*;

    alu_state_t  state_reg, state_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [31:0] res_reg, res_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic        is_mod_reg, is_mod_next;
    logic [31:0] prod;
    logic [31:0] mag_a, mag_b;
    logic [32:0] trial;

    assign prod  = a_in * b_in;
    assign mag_a = a_in[31] ? (32'd0 - a_in) : a_in;
    assign mag_b = b_in[31] ? (32'd0 - b_in) : b_in;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, div_reg};

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        res_reg    <= res_next;
        cnt_reg    <= cnt_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        is_mod_reg <= is_mod_next;
    end

    // Next state and datapath
    always_comb begin
        state_next  = state_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        res_next    = res_reg;
        cnt_next    = cnt_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        is_mod_next = is_mod_reg;
        case (state_reg)
            A_IDLE: begin
                if (ctl.start) begin
                    state_next = A_DONE;
                    case (ctl.func)
                        FN_ADD: res_next = a_in + b_in;
                        FN_SUB: res_next = a_in - b_in;
                        FN_MUL: res_next = prod;
                        FN_DIV, FN_MOD: begin
                            quo_next    = mag_a;
                            rem_next    = '0;
                            div_next    = mag_b;
                            cnt_next    = '0;
                            neg_q_next  = a_in[31] ^ b_in[31];
                            neg_r_next  = a_in[31];
                            is_mod_next = (ctl.func == FN_MOD);
                            state_next  = A_DIV;
                        end
                        default: res_next = '0;
                    endcase
                end
            end
            A_DIV: begin
                // One restoring step per cycle, quotient bits shift in from the right
                if (!trial[32]) begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = A_SIGN;
                end
            end
            A_SIGN: begin
                // Truncate toward zero: remainder follows the dividend sign
                if (is_mod_reg) begin
                    res_next = neg_r_reg ? (32'd0 - rem_reg) : rem_reg;
                end else begin
                    res_next = neg_q_reg ? (32'd0 - quo_reg) : quo_reg;
                end
                state_next = A_DONE;
            end
            A_DONE: begin
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    assign result   = res_reg;
    assign sts.busy = (state_reg != A_IDLE);
    assign sts.done = (state_reg == A_DONE);

endmodule

FILE: rtl/core/rpn_stack_calculator_top.sv
// Reverse Polish integer evaluator: top level with token sequencer and stack.
//
// Input beats on s_ carry one token: s_tuser the function (push, add, subtract,
// multiply, divide, modulo), s_tdata the 31-bit number to push, s_tlast the
// finish marker that pops and reports the top word and clears the stack.
// Every token gives one output beat on m_: m_tuser the status (ok, underflow,
// divide by zero, halted), m_tdata the popped word on a clean finish else zero,
// m_tlast set when the beat answers a finish.
// One token is in flight at a time; s_tready is high only while idle.
// Push, ignored and halted tokens and errors found at decode go straight to output;
// finish with a word on the stack, a zero divisor or a missing second operand first
// read the top word; add, subtract and multiply also read the second operand and run
// the shared arithmetic unit, whose divider takes 32 steps for divide and modulo.
// With the output register free, the sequencer returns to idle as the result loads,
// and s_tready rises in the cycle after. The stack lives in a registered-read RAM.
// The result sits in an output register; the next token is taken while it waits,
// and a second result waits in the sequencer until the receiver takes the first.
// Reset (aresetn low, synchronous) empties the stack and clears the error;
// stack contents are not cleared and never read before being written.
`timescale 1ns / 1ps

module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] operand, [31] zero fill
    input  logic [2:0]  s_tuser,   // [2:0] func
    input  logic        s_tlast,   // finish
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // done_res
);
    import rpn_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        err_reg, err_next;
    logic [31:0]       b_reg, b_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [31:0]       res_value_reg, res_value_next;
    logic [2:0]        func_reg;
    logic [30:0]       operand_reg;
    logic              fin_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;
    logic [1:0]        m_tuser_reg;
    logic              m_tlast_reg;
    logic              s_accept;
    logic              out_load;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       rd_data;
    logic [CNT_W-1:0]  top_idx;
    logic [CNT_W-1:0]  second_idx;

    alu_ctl_t          alu_ctl;
    alu_sts_t          alu_sts;
    logic [31:0]       alu_result;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_load   = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
    assign top_idx    = count_reg - CNT_W'(1);
    assign second_idx = count_reg - CNT_W'(2);

    // Stack storage
    rpn_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared arithmetic unit
    rpn_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (alu_ctl),
        .a_in    (rd_data),
        .b_in    (b_reg),
        .result  (alu_result),
        .sts     (alu_sts)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            err_reg      <= STS_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        b_reg          <= b_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (s_accept) begin
            func_reg    <= s_tuser;
            operand_reg <= s_tdata[30:0];
            fin_reg     <= s_tlast;
        end
        if (out_load) begin
            m_tdata_reg <= res_value_reg;
            m_tuser_reg <= res_status_reg;
            m_tlast_reg <= fin_reg;
        end
    end

    // Token sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        b_next          = b_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[ADDR_W-1:0];
        wr_data         = {1'b0, operand_reg};
        rd_en           = 1'b0;
        rd_addr         = top_idx[ADDR_W-1:0];
        alu_ctl.start   = 1'b0;
        alu_ctl.func    = func_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_status_next = STS_OK;
                res_value_next  = '0;
                state_next      = S_EMIT;
                if (fin_reg) begin
                    // Finish: report sticky error or empty stack, else fetch top
                    count_next = '0;
                    err_next   = STS_OK;
                    if (err_reg != STS_OK) begin
                        res_status_next = err_reg;
                    end else if (count_reg == '0) begin
                        res_status_next = STS_UNDER;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = S_FIN_GET;
                    end
                end else if (err_reg != STS_OK) begin
                    res_status_next = STS_HALTED;
                end else begin
                    case (func_reg)
                        FN_PUSH: begin
                            // Drop the word when the stack is full
                            if (count_reg < FULL_CNT) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: begin
                            if (count_reg == '0) begin
                                res_status_next = STS_UNDER;
                                err_next        = STS_UNDER;
                            end else begin
                                rd_en      = 1'b1;
                                state_next = S_CHK_B;
                            end
                        end
                        default: begin
                            res_status_next = STS_OK;
                        end
                    endcase
                end
            end
            S_FIN_GET: begin
                res_value_next = rd_data;
                state_next     = S_EMIT;
            end
            S_CHK_B: begin
                // Top word is the right operand; check divisor, then depth
                b_next     = rd_data;
                state_next = S_EMIT;
                if ((func_reg inside {FN_DIV, FN_MOD}) && (rd_data == '0)) begin
                    res_status_next = STS_DIVZ;
                    err_next        = STS_DIVZ;
                end else if (count_reg < CNT_W'(2)) begin
                    res_status_next = STS_UNDER;
                    err_next        = STS_UNDER;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = second_idx[ADDR_W-1:0];
                    state_next = S_LD_A;
                end
            end
            S_LD_A: begin
                alu_ctl.start = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC: begin
                // Replace the two operands with the result
                if (alu_sts.done) begin
                    wr_en      = 1'b1;
                    wr_addr    = second_idx[ADDR_W-1:0];
                    wr_data    = alu_result;
                    count_next = top_idx;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // Stack count stays within the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("stack count beyond depth");

    // A finish leaves an empty stack and no error behind
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) && fin_reg |-> (count_reg == '0) && (err_reg == STS_OK))
        else $error("finish did not clear stack state");

    // Only finish beats carry a nonzero value
    a_value_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata == '0))
        else $error("value on a non-finish beat");

    // The arithmetic unit is started only when idle
    a_alu_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_ctl.start |-> !alu_sts.busy)
        else $error("arithmetic unit started while busy");
`endif

endmodule

FILE: dv/tb_rpn_stack_calculator_top.sv
// Self-checking testbench for the RPN stack calculator stream interface.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator_top;
    import rpn_pkg::*;

    localparam int STACK_DEPTH = 128;
    localparam int TARGET_TOKENS = 1800;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 60;
    localparam longint CYCLE_LIMIT = 1000000;

    // One token as it enters the block
    typedef struct {
        logic [2:0]  func;
        logic [30:0] operand;
        logic        finish;
    } token_t;

    // One result beat
    typedef struct {
        logic [1:0]  status;
        logic [31:0] value;
        logic        done;
    } calc_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // [30:0] operand, [31] zero fill
    logic [2:0]  s_tuser = '0;      // [2:0] func
    logic        s_tlast = 1'b0;    // finish
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] value
    logic [1:0]  m_tuser;           // [1:0] status
    logic        m_tlast;           // done_res

    rpn_stack_calculator_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    token_t    token_q[$];
    calc_res_t result_q[$];

    // Shadow copy of the calculator state
    logic [31:0] calc_stack[STACK_DEPTH];
    int          calc_depth = 0;
    logic [1:0]  calc_err = STS_OK;
    int          peak_depth = 0;

    int     useful_tokens = 0;
    int     total_tokens = 0;
    int     tokens_drawn = 0;
    int     beats_in = 0;
    int     results_seen = 0;
    int     finish_seen = 0;
    int     error_seen = 0;
    int     fail_count = 0;
    int     pace_phase = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    longint cycles = 0;
    token_t tok_next;
    calc_res_t res_want;

    // Evaluate one token against the shadow stack and return its result
    function automatic calc_res_t eval_token(token_t t);
        calc_res_t r;
        logic [31:0] a, b, ma, mb, q, rm;
        r.status = STS_OK;
        r.value = '0;
        r.done = t.finish;
        if (t.finish) begin
            if (calc_err != STS_OK)
                r.status = calc_err;
            else if (calc_depth == 0)
                r.status = STS_UNDER;
            else
                r.value = calc_stack[calc_depth - 1];
            calc_depth = 0;
            calc_err = STS_OK;
        end else if (calc_err != STS_OK) begin
            r.status = STS_HALTED;
        end else if (t.func == FN_PUSH) begin
            // drop the word silently when full
            if (calc_depth < STACK_DEPTH) begin
                calc_stack[calc_depth] = {1'b0, t.operand};
                calc_depth++;
                if (calc_depth > peak_depth)
                    peak_depth = calc_depth;
            end
        end else if (t.func <= FN_MOD) begin
            // divisor first, then zero divisor, then second operand
            if (calc_depth == 0) begin
                r.status = STS_UNDER;
            end else if (t.func >= FN_DIV && calc_stack[calc_depth - 1] == 32'd0) begin
                r.status = STS_DIVZ;
            end else if (calc_depth < 2) begin
                r.status = STS_UNDER;
            end else begin
                b = calc_stack[calc_depth - 1];
                a = calc_stack[calc_depth - 2];
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = (t.func >= FN_DIV) ? ma / mb : '0;
                rm = (t.func >= FN_DIV) ? ma % mb : '0;
                case (t.func)
                    FN_ADD: calc_stack[calc_depth - 2] = a + b;
                    FN_SUB: calc_stack[calc_depth - 2] = a - b;
                    FN_MUL: calc_stack[calc_depth - 2] = a * b;
                    FN_DIV: calc_stack[calc_depth - 2] = (a[31] ^ b[31]) ? -q : q;
                    default: calc_stack[calc_depth - 2] = a[31] ? -rm : rm;
                endcase
                calc_depth--;
            end
            calc_err = r.status;
        end
        return r;
    endfunction

    // Idle percentage for each side in the current pacing phase
    function automatic int idle_pct(bit sender);
        case (pace_phase)
            0: return sender ? 17 : 64;
            1: return sender ? 64 : 17;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at result %0d: got 0x%08h, want 0x%08h",
                 field, results_seen, got, want);
        fail_count++;
    endtask

    task automatic add_tok(logic [2:0] fn, logic [30:0] opnd, bit fin, bit counted);
        token_t t;
        t.func = fn;
        t.operand = opnd;
        t.finish = fin;
        token_q.push_back(t);
        if (counted)
            useful_tokens++;
    endtask

    // Operand mix: small values (zero divisors, short products), full range, extremes
    function automatic logic [30:0] rand_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return 31'($urandom_range(20));
            4, 5, 6, 7: return 31'($urandom());
            8:          return 31'h7FFF_FFFF;
            default:    return 31'($urandom_range(1, 3));
        endcase
    endfunction

    // One expression: mostly well formed, some broken, some noise
    task automatic gen_expr();
        int kind, n, d, pushed;
        kind = $urandom_range(99);
        if (kind < 12) begin
            n = $urandom_range(1, 6);
            repeat (n)
                add_tok(3'($urandom_range(7)), rand_operand(), $urandom_range(9) == 0, 1'b0);
            add_tok(3'($urandom_range(7)), 31'($urandom()), 1'b1, 1'b0);
        end else begin
            n = $urandom_range(1, 12);
            d = 0;
            pushed = 0;
            while (pushed < n || d > 1) begin
                if (d < 2 || (pushed < n && $urandom_range(1) == 0)) begin
                    add_tok(FN_PUSH, rand_operand(), 1'b0, 1'b1);
                    d++;
                    pushed++;
                end else begin
                    add_tok(3'($urandom_range(FN_ADD, FN_MOD)), 31'($urandom()), 1'b0, 1'b1);
                    d--;
                end
            end
            // break it: a stray operator, then a token that must be halted
            if (kind < 22) begin
                add_tok(3'($urandom_range(FN_ADD, FN_MOD)), 31'($urandom()), 1'b0, 1'b1);
                add_tok(FN_PUSH, rand_operand(), 1'b0, 1'b1);
            end
            add_tok(3'($urandom_range(7)), 31'($urandom()), 1'b1, 1'b1);
        end
    endtask

    // Drive token beats from the queue and predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tok_next.func = s_tuser;
                tok_next.operand = s_tdata[30:0];
                tok_next.finish = s_tlast;
                result_q.push_back(eval_token(tok_next));
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (token_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    tok_next = token_q.pop_front();
                    tokens_drawn++;
                    pace_phase = (tokens_drawn < total_tokens / 3) ? 0 :
                                 (tokens_drawn < 2 * total_tokens / 3) ? 1 : 2;
                    s_tvalid <= 1'b1;
                    s_tuser <= tok_next.func;
                    s_tdata <= {1'b0, tok_next.operand};
                    s_tlast <= tok_next.finish;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off the receiver once for a long stretch so the block backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && beats_in >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Check result beats against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, '0);
                end else begin
                    res_want = result_q.pop_front();
                    if (m_tuser !== res_want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(res_want.status));
                    if (m_tdata !== res_want.value)
                        report_mismatch("value", m_tdata, res_want.value);
                    if (m_tlast !== res_want.done)
                        report_mismatch("done", 32'(m_tlast), 32'(res_want.done));
                    if (res_want.done)
                        finish_seen++;
                    if (res_want.status != STS_OK)
                        error_seen++;
                end
                results_seen++;
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        // Directed: empty finish with junk in the ignored fields
        add_tok(FN_DIV, 31'h7FFF_FFFF, 1'b1, 1'b1);
        // underflow on empty, then a halted push
        add_tok(FN_ADD, '0, 1'b0, 1'b1);
        add_tok(FN_PUSH, 31'd5, 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b1, 1'b1);
        // divide by zero with two words
        add_tok(FN_PUSH, 31'h7FFF_FFFF, 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b0, 1'b1);
        add_tok(FN_DIV, '0, 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b1, 1'b1);
        // zero divisor is seen before the missing second operand
        add_tok(FN_PUSH, '0, 1'b0, 1'b1);
        add_tok(FN_MOD, '0, 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b1, 1'b1);
        // missing second operand
        add_tok(FN_PUSH, 31'd7, 1'b0, 1'b1);
        add_tok(FN_SUB, '0, 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b1, 1'b1);
        // most negative word divided by minus one
        add_tok(FN_PUSH, 31'h4000_0000, 1'b0, 1'b1);
        add_tok(FN_PUSH, 31'd2, 1'b0, 1'b1);
        add_tok(FN_MUL, '0, 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b0, 1'b1);
        add_tok(FN_PUSH, 31'd1, 1'b0, 1'b1);
        add_tok(FN_SUB, '0, 1'b0, 1'b1);
        add_tok(FN_DIV, '0, 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b1, 1'b1);
        // unused selectors are skipped, then a plain modulo
        add_tok(FN_PUSH, 31'd9, 1'b0, 1'b1);
        add_tok(3'd6, 31'h7FFF_FFFF, 1'b0, 1'b1);
        add_tok(3'd7, 31'h5555_5555, 1'b0, 1'b1);
        add_tok(FN_PUSH, 31'd4, 1'b0, 1'b1);
        add_tok(FN_MOD, '0, 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b1, 1'b1);

        // Overfill the stack, fold a few words, then fill exactly
        repeat (STACK_DEPTH + 12)
            add_tok(FN_PUSH, rand_operand(), 1'b0, 1'b1);
        repeat (10)
            add_tok(3'($urandom_range(FN_ADD, FN_MUL)), '0, 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b1, 1'b1);
        repeat (STACK_DEPTH)
            add_tok(FN_PUSH, rand_operand(), 1'b0, 1'b1);
        add_tok(FN_PUSH, '0, 1'b1, 1'b1);

        while (useful_tokens < TARGET_TOKENS)
            gen_expr();
        total_tokens = token_q.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk); while (token_q.size() != 0 || s_tvalid);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d tokens and %0d results: %0d finish beats, %0d error statuses.",
                 beats_in, results_seen, finish_seen, error_seen);
        $display("Stack peaked at %0d of %0d words under three pacing phases and one long stall.",
                 peak_depth, STACK_DEPTH);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
